>>> rtl/core/bmib_pkg.sv
// Shared types, constants and register indexes for the mask boundary block.
`default_nettype none

package bmib_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int COORD_W   = 10;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTLINE_MODE = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;
    localparam logic             OUTLINE_MODE_RST = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic op;
        logic pixel_in;
    } in_item_t;

    typedef struct packed {
        logic               mask_bit;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic               frame_last;
    } out_item_t;

    // Which sides of the 3x3 window fall outside the frame.
    typedef struct packed {
        logic left_out;
        logic right_out;
        logic top_out;
        logic bottom_out;
    } bmib_border_t;

endpackage

`default_nettype wire

>>> rtl/core/binary_mask_inner_boundary.sv
// Top level: raster binary mask to inner boundary (or pass-through) stream.
`default_nettype none

// Takes one mask pixel per cycle in raster order, unless a stalled output
// holds it off, and returns one result pixel per transaction once the
// pipeline has filled: in outline mode a 1 marks an object pixel with a
// background pixel among its eight in-frame neighbors (pixels beyond the
// frame count as object), in plain mode the mask bit is returned as is.
// Each result lags its input by frame_width + 1 transactions, so after the
// last pixel of a frame the source sends frame_width + 1 more transactions
// (flush, or any pixel, whose bit is dropped) to drain the tail; frame_last
// marks the final result, after which the next frame starts at (0,0). A
// flush before the frame's last pixel is taken and ignored. Throughput is
// one transaction per cycle while the output is not stalled: the two previous
// rows live in one line-store memory that is read when a pixel is accepted
// and written back as the item leaves the work stage, with a bypass for
// single-column frames. Accepted pixels pass a one-entry work stage and a
// one-entry output register, which offers the result. The line store needs
// no clearing pass: stale entries only ever fall outside the frame.
// Writing frame_width or frame_height restarts the stream at (0,0); sizes of
// zero count as 1 and sizes above MAX_WIDTH / MAX_HEIGHT count as the maximum.
module binary_mask_inner_boundary
    import bmib_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_item_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_item_t                 out_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int EROW_W = $clog2(MAX_HEIGHT);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);   // input row runs to height + 1

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic             outline_mode_reg;
    logic             restart;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            outline_mode_reg <= OUTLINE_MODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_OUTLINE_MODE: outline_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign restart = cfg_we && ((cfg_index == REG_FRAME_WIDTH)
                             || (cfg_index == REG_FRAME_HEIGHT));

    // Effective (clamped) frame size
    logic [W_W-1:0] w_eff;
    logic [H_W-1:0] h_eff;

    always_comb
    begin
        priority if (frame_width_reg == '0)
            w_eff = W_W'(1);
        else if (int'(frame_width_reg) > MAX_WIDTH)
            w_eff = W_W'(MAX_WIDTH);
        else
            w_eff = W_W'(frame_width_reg);

        priority if (frame_height_reg == '0)
            h_eff = H_W'(1);
        else if (int'(frame_height_reg) > MAX_HEIGHT)
            h_eff = H_W'(MAX_HEIGHT);
        else
            h_eff = H_W'(frame_height_reg);
    end

    // ---------------- input side: position counters ----------------
    logic [COL_W-1:0]  in_col_reg;
    logic [ROW_W-1:0]  in_row_reg;
    logic [COL_W-1:0]  emit_col_reg;
    logic [EROW_W-1:0] emit_row_reg;

    logic              in_fire;
    logic              draining;
    logic              work;
    logic              emit;
    logic              pix;
    logic              in_col_wrap;
    logic              ex_last;
    logic              ey_last;
    logic              last;
    logic [COL_W-1:0]  in_col_next;
    logic [ROW_W-1:0]  in_row_next;
    logic [COL_W-1:0]  emit_col_next;
    logic [EROW_W-1:0] emit_row_next;

    assign in_fire  = in_valid && in_ready;
    assign draining = in_row_reg >= ROW_W'(h_eff);
    // Flush before the last pixel of the frame does nothing.
    assign work     = in_fire && (draining || (in_data.op == OP_PIXEL));
    assign pix      = draining ? 1'b0 : in_data.pixel_in;
    assign emit     = (in_row_reg > ROW_W'(1))
                   || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));

    assign in_col_wrap = (W_W'(in_col_reg) + W_W'(1)) >= w_eff;
    assign ex_last     = (W_W'(emit_col_reg) + W_W'(1)) >= w_eff;
    assign ey_last     = (H_W'(emit_row_reg) + H_W'(1)) >= h_eff;
    assign last        = ex_last && ey_last;

    always_comb
    begin
        in_col_next   = in_col_reg + COL_W'(1);
        in_row_next   = in_row_reg;
        emit_col_next = emit_col_reg + COL_W'(1);
        emit_row_next = emit_row_reg;
        if (in_col_wrap)
        begin
            in_col_next = '0;
            in_row_next = in_row_reg + ROW_W'(1);
        end
        if (ex_last)
        begin
            emit_col_next = '0;
            emit_row_next = emit_row_reg + EROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            emit_col_reg <= '0;
            emit_row_reg <= '0;
        end
        else if (restart || (work && emit && last))
        begin
            // new frame size, or frame complete
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            emit_col_reg <= '0;
            emit_row_reg <= '0;
        end
        else if (work)
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            if (emit)
            begin
                emit_col_reg <= emit_col_next;
                emit_row_reg <= emit_row_next;
            end
        end
    end

    // ---------------- work stage: line store read returns here ----------------
    logic               s1_valid_reg;
    logic               s1_emit_reg;
    logic               s1_pix_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [COORD_W-1:0] s1_x_reg;
    logic [COORD_W-1:0] s1_y_reg;
    logic               s1_last_reg;
    bmib_border_t       s1_border_reg;
    logic               s1_adv;
    logic [1:0]         ls_rd_data;
    logic [1:0]         ls_wr_data;
    logic [2:0]         triple;
    logic               win_bit;

    // A result-less item never waits on the output register.
    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || !out_valid || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= work;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work)
        begin
            s1_emit_reg              <= emit;
            s1_pix_reg               <= pix;
            s1_col_reg               <= in_col_reg;
            s1_x_reg                 <= COORD_W'(emit_col_reg);
            s1_y_reg                 <= COORD_W'(emit_row_reg);
            s1_last_reg              <= last;
            s1_border_reg.left_out   <= (emit_col_reg == '0);
            s1_border_reg.right_out  <= ex_last;
            s1_border_reg.top_out    <= (emit_row_reg == '0);
            s1_border_reg.bottom_out <= ey_last;
        end
    end

    // Entry bit 1 = row above, bit 0 = row two above.
    assign triple     = {s1_pix_reg, ls_rd_data[1], ls_rd_data[0]};
    assign ls_wr_data = {s1_pix_reg, ls_rd_data[1]};

    bmib_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (work),
        .rd_addr (in_col_reg),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (ls_wr_data),
        .rd_data (ls_rd_data)
    );

    bmib_window u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (s1_adv),
        .triple       (triple),
        .border       (s1_border_reg),
        .outline_mode (outline_mode_reg),
        .mask_bit     (win_bit)
    );

    // ---------------- output register ----------------
    logic      out_valid_reg;
    out_item_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            out_data_reg.mask_bit   <= win_bit;
            out_data_reg.out_x      <= s1_x_reg;
            out_data_reg.out_y      <= s1_y_reg;
            out_data_reg.frame_last <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- assertions ----------------
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_emit_reg) |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before transaction");

    a_stage_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emit_reg && out_valid_reg && !out_ready) |=> s1_valid_reg)
        else $error("work stage item lost during output stall");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled with empty work stage");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_row_reg <= (ROW_W'(h_eff) + ROW_W'(1)))
        else $error("input row counter ran past drain window");

endmodule

`default_nettype wire

>>> rtl/core/bmib_line_store.sv
// Two-row line store: one memory, entry = {row above, row two above}, with bypass.
`default_nettype none

module bmib_line_store
    import bmib_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int ADDR_W   = $clog2(MAX_WIDTH)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [1:0]        wr_data,
    output logic      [1:0]        rd_data
);

    logic [1:0] mem [MAX_WIDTH];
    logic [1:0] q_reg;
    logic [1:0] byp_reg;
    logic       hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg   <= mem[rd_addr];
            byp_reg <= wr_data;
        end
    end

    // Same-entry read and write in one cycle: take the new data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = hit_reg ? byp_reg : q_reg;

endmodule

`default_nettype wire

>>> rtl/core/bmib_window.sv
// 3x3 window shift register and outline decision.
`default_nettype none

module bmib_window
    import bmib_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         advance,
    input  wire logic [2:0]   triple,
    input  wire bmib_border_t border,
    input  wire logic         outline_mode,
    output logic              mask_bit
);

    logic [8:0] window_reg;
    logic [8:0] window_next;
    logic [2:0] left_col;
    logic [2:0] mid_col;
    logic [2:0] right_col;
    logic       center;
    logic       any_zero;

    // Bit 0 top, bit 1 middle, bit 2 bottom; out-of-frame bits count as object.
    function automatic logic col_has_zero(input logic [2:0] t, input logic col_out,
                                          input logic top_out, input logic bottom_out);
        logic z;
        z = (!top_out && !t[0]) || !t[1] || (!bottom_out && !t[2]);
        return !col_out && z;
    endfunction

    assign window_next = {triple, window_reg[8:3]};
    assign left_col    = window_next[2:0];
    assign mid_col     = window_next[5:3];
    assign right_col   = window_next[8:6];
    assign center      = mid_col[1];

    assign any_zero = col_has_zero(left_col, border.left_out, border.top_out, border.bottom_out)
                   || col_has_zero(mid_col, 1'b0, border.top_out, border.bottom_out)
                   || col_has_zero(right_col, border.right_out, border.top_out,
                                   border.bottom_out);

    assign mask_bit = outline_mode ? (center && any_zero) : center;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (advance)
        begin
            window_reg <= window_next;
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the raster mask inner-boundary block.
`timescale 1ns / 100ps

module testbench;
    import bmib_pkg::*;

    localparam int MAX_W          = MAX_WIDTH_DEF;
    localparam int MAX_H          = MAX_HEIGHT_DEF;
    localparam int RANDOM_ITEMS   = 380;
    localparam int SETTLE_CYCLES  = 8;     // block is two stages deep
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either side

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;

    binary_mask_inner_boundary uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Boundary predictor state (mirrors the block after reset)
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] width_cfg   = FRAME_WIDTH_RST;
    logic [CFG_W-1:0] height_cfg  = FRAME_HEIGHT_RST;
    logic             outline_cfg = OUTLINE_MODE_RST;

    bit          row_prev1 [MAX_W];   // row just above the incoming pixel
    bit          row_prev2 [MAX_W];   // row two above
    logic [8:0]  window_q  = '0;      // {right, mid, left} column triples
    int unsigned in_col    = 0;
    int unsigned in_row    = 0;
    int unsigned emit_col  = 0;
    int unsigned emit_row  = 0;

    in_item_t  pixel_feed[$];         // transactions waiting for the driver
    out_item_t expected_pixels[$];    // predicted results, oldest first

    int  fail_count   = 0;
    int  useful_items = 0;            // pixels and drain ticks, noise excluded
    int  feed_gap     = 0;
    int  sink_stall   = 0;
    int  idle_cycles  = 0;
    bit  feed_calm    = 1'b0;
    bit  sink_calm    = 1'b0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // In-frame background pixels in one column triple (bit0 top .. bit2 bottom).
    function automatic int unsigned count_bg(input logic [2:0] triple, input bit col_out,
                                             input int unsigned ey, input int unsigned h);
        int unsigned n;
        n = 0;
        if (col_out) return 0;
        if (ey != 0 && !triple[0]) n++;
        if (!triple[1]) n++;
        if (ey + 1 < h && !triple[2]) n++;
        return n;
    endfunction

    function automatic void restart_stream();
        in_col   = 0;
        in_row   = 0;
        emit_col = 0;
        emit_row = 0;
    endfunction

    // Advance the predictor by one accepted transaction; returns 1 when a
    // result pixel comes out of it.
    function automatic bit boundary_step(input in_item_t item, output out_item_t res);
        int unsigned w, h, col, ex, ey, zeros;
        logic [2:0]  triple;
        bit          pix, draining, emit, last, center;
        res      = '0;
        w        = clamp_dim(width_cfg, MAX_W);
        h        = clamp_dim(height_cfg, MAX_H);
        draining = (in_row >= h);
        pix      = item.pixel_in;
        // flush before the frame is complete: swallowed
        if (!draining && item.op == OP_FLUSH) return 0;
        // past the last pixel every tick drains, its bit dropped
        if (draining) pix = 1'b0;

        col = (in_col >= w) ? w - 1 : in_col;
        triple = {pix, row_prev1[col], row_prev2[col]};
        row_prev2[col] = row_prev1[col];
        row_prev1[col] = pix;
        window_q = {triple, window_q[8:3]};

        // first result once the pixel below-right of (0,0) has arrived
        emit = (in_row > 1) || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (!emit) return 0;

        ex     = emit_col;
        ey     = emit_row;
        center = window_q[4];
        zeros  = count_bg(window_q[2:0], ex == 0, ey, h)
               + count_bg(window_q[5:3], 1'b0, ey, h)
               + count_bg(window_q[8:6], ex + 1 >= w, ey, h);
        last   = (ex + 1 >= w) && (ey + 1 >= h);

        res.mask_bit   = outline_cfg ? (center && zeros != 0) : center;
        res.out_x      = ex[COORD_W-1:0];
        res.out_y      = ey[COORD_W-1:0];
        res.frame_last = last;

        if (last) begin
            restart_stream();
        end
        else begin
            emit_col++;
            if (emit_col >= w) begin
                emit_col = 0;
                emit_row++;
            end
        end
        return 1;
    endfunction

    // Mostly short gaps, a few long ones; none at all during calm stretches.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10) $display("%0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Driver: one transaction from pixel_feed at a time, random gaps
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : feed_driver
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            feed_gap <= 0;
        end
        else
        begin
            if ($urandom_range(149) == 0) feed_calm <= !feed_calm;
            // payload only moves once the current transaction is taken
            if (!in_valid || in_ready)
            begin
                if (feed_gap > 0)
                begin
                    in_valid <= 1'b0;
                    feed_gap <= feed_gap - 1;
                end
                else if (pixel_feed.size() != 0)
                begin
                    in_data  <= pixel_feed.pop_front();
                    in_valid <= 1'b1;
                    feed_gap <= pick_gap(feed_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check results first, then predict from the accepted input
    // (a result can never stem from an input taken at the same edge)
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_check
        out_item_t want;
        out_item_t fresh;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            sink_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    note_failure($sformatf("unexpected result bit=%0d x=%0d y=%0d last=%0d",
                        out_data.mask_bit, out_data.out_x, out_data.out_y,
                        out_data.frame_last));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_data.mask_bit !== want.mask_bit || out_data.out_x !== want.out_x ||
                        out_data.out_y !== want.out_y ||
                        out_data.frame_last !== want.frame_last)
                        note_failure($sformatf(
                            "mismatch: expected bit=%0d x=%0d y=%0d last=%0d, got bit=%0d x=%0d y=%0d last=%0d",
                            want.mask_bit, want.out_x, want.out_y, want.frame_last,
                            out_data.mask_bit, out_data.out_x, out_data.out_y,
                            out_data.frame_last));
                end
            end

            if (in_valid && in_ready)
            begin
                if (boundary_step(in_data, fresh))
                    expected_pixels.insert(expected_pixels.size(), fresh);
            end

            // receiver back-pressure
            if ($urandom_range(149) == 0) sink_calm <= !sink_calm;
            if (sink_stall > 0)
            begin
                out_ready  <= 1'b0;
                sink_stall <= sink_stall - 1;
            end
            else
            begin
                out_ready  <= 1'b1;
                sink_stall <= pick_gap(sink_calm);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transaction means the block hung
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout with %0d results outstanding", expected_pixels.size());
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input logic op, input logic pix);
        in_item_t item;
        item.op       = op;
        item.pixel_in = pix;
        pixel_feed.insert(pixel_feed.size(), item);
    endtask

    // Register write at a rising edge; the mirror follows right away since
    // writes only happen while nothing is in flight.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
        begin
            width_cfg = val;
            restart_stream();
        end
        else if (idx == REG_FRAME_HEIGHT)
        begin
            height_cfg = val;
            restart_stream();
        end
        else if (idx == REG_OUTLINE_MODE)
        begin
            outline_cfg = val[0];
        end
        @(negedge clk);
    endtask

    // Queue the first 'cut' pixels of a fw x fh frame; a whole frame gets its
    // fw + 1 drain ticks, some of them pixels whose bit is dropped.
    task automatic feed_frame(input int fw, input int fh, input int density, input int cut);
        int n;
        @(negedge clk);
        for (n = 0; n < cut; n++)
        begin
            // stray flush inside the frame: taken and ignored
            if ($urandom_range(99) < 4) queue_item(OP_FLUSH, 1'($urandom_range(1)));
            queue_item(OP_PIXEL, $urandom_range(99) < density);
        end
        useful_items += cut;
        if (cut == fw * fh)
        begin
            for (n = 0; n <= fw; n++)
                queue_item(($urandom_range(99) < 25) ? OP_PIXEL : OP_FLUSH,
                           1'($urandom_range(1)));
            useful_items += fw + 1;
            // extra flush after frame_last lands in the next frame: ignored
            if ($urandom_range(99) < 10) queue_item(OP_FLUSH, 1'($urandom_range(1)));
        end
    endtask

    // Idle means: nothing queued, nothing offered, nothing owed, plus a
    // settling wait for ignored flushes still in the pipe.
    task automatic wait_drained();
        do @(negedge clk);
        while (pixel_feed.size() != 0 || in_valid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned raw_w, raw_h, fw, fh;
        int          density, k, n, start_count;
        bit          must_resize;
        logic [8:0]  hole;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed: 3x3 frames, outline mode left at its reset value ---
        write_reg(REG_FRAME_WIDTH, 11'd3);
        write_reg(REG_FRAME_HEIGHT, 11'd3);
        // solid frame: edge counts as object, so no outline at all;
        // a flush mid frame is swallowed
        for (n = 0; n < 9; n++)
        begin
            if (n == 4) queue_item(OP_FLUSH, 1'b1);
            queue_item(OP_PIXEL, 1'b1);
        end
        // drain: a pixel here acts as a flush
        for (n = 0; n < 4; n++)
            queue_item((n == 1) ? OP_PIXEL : OP_FLUSH, 1'b1);
        // ring with a hole in the middle: all eight ring pixels are outline
        hole = 9'b111_101_111;
        for (n = 0; n < 9; n++)
            queue_item(OP_PIXEL, hole[n]);
        for (n = 0; n < 4; n++)
            queue_item(OP_FLUSH, 1'b0);
        wait_drained();

        // partial frame, then a size write restarts at (0,0)
        feed_frame(3, 3, 50, 5);
        wait_drained();

        // sizes of zero count as one: 1x1 frame in plain mode
        write_reg(REG_OUTLINE_MODE, CFG_W'(1'b0));
        write_reg(REG_FRAME_WIDTH, 11'd0);
        write_reg(REG_FRAME_HEIGHT, 11'd0);
        queue_item(OP_PIXEL, 1'b1);
        queue_item(OP_FLUSH, 1'b0);
        queue_item(OP_PIXEL, 1'b0);
        wait_drained();

        // oversize height clamps: single column, full height
        write_reg(REG_OUTLINE_MODE, CFG_W'(1'b1));
        write_reg(REG_FRAME_WIDTH, 11'd1);
        write_reg(REG_FRAME_HEIGHT, 11'h7FF);
        feed_frame(1, MAX_H, 70, MAX_H);
        wait_drained();

        // --- random phases: mostly whole frames, some cut short ---
        must_resize = 1'b1;
        start_count = useful_items;
        while (useful_items - start_count < RANDOM_ITEMS)
        begin
            if (must_resize || $urandom_range(99) < 70)
            begin
                raw_w = ($urandom_range(99) < 6) ? 0 :
                        $urandom_range(1, ($urandom_range(99) < 70) ? 6 : 20);
                raw_h = ($urandom_range(99) < 6) ? 0 :
                        $urandom_range(1, ($urandom_range(99) < 70) ? 5 : 10);
                write_reg(REG_FRAME_WIDTH, raw_w[CFG_W-1:0]);
                write_reg(REG_FRAME_HEIGHT, raw_h[CFG_W-1:0]);
            end
            if ($urandom_range(99) < 35)
                write_reg(REG_OUTLINE_MODE, CFG_W'($urandom_range(1)));
            fw = clamp_dim(width_cfg, MAX_W);
            fh = clamp_dim(height_cfg, MAX_H);
            case ($urandom_range(2))
                0:       density = 10;
                1:       density = 50;
                default: density = 90;
            endcase
            for (k = $urandom_range(1, 3); k > 0; k--)
                feed_frame(fw, fh, density, fw * fh);
            must_resize = 1'b0;
            // broken frame: pending results get dropped by the next size write
            if ($urandom_range(99) < 15)
            begin
                feed_frame(fw, fh, density, $urandom_range(1, fw * fh));
                must_resize = 1'b1;
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
